[sv/cptsm_pkg.sv]
// ----------------------------------------------------------------------------
// cptsm_pkg
// Shared types and constants for the cross-page tag share marker.
// ----------------------------------------------------------------------------
package cptsm_pkg;

	localparam int TAG_COUNT   = 4096;
	localparam int PAGE_BITS   = 16;
	localparam int TAG_AW      = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
	localparam int EPOCH_BITS  = 8;

	localparam int PAGE_W      = 16;
	localparam int TAG_W       = 12;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 16;

	localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = '1;

	// one table entry: set epoch, seen mark, shared flag, first page
	typedef struct packed {
		logic [EPOCH_BITS-1:0] epoch;
		logic                  seen;
		logic                  shrd;
		logic [PAGE_BITS-1:0]  page;
	} entry_t;

	typedef struct packed {
		logic in_ready;
		logic cap;
		logic clr_wr;
		logic rd_en;
		logic upd;
	} cmd_t;

	typedef struct packed {
		logic wrap_now;
		logic clr_last;
		logic out_busy;
	} stat_t;

endpackage

[sv/cptsm_ctrl.sv]
// ----------------------------------------------------------------------------
// cptsm_ctrl
// Sequencer: clearing pass, word capture, table read, update and result load.
// ----------------------------------------------------------------------------
module cptsm_ctrl import cptsm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_UPD
	} state_t;

	state_t state_q;
	logic   pend_q;   // a word waits for the clearing pass to finish

	always_comb begin
		cmd          = '0;
		cmd.in_ready = (state_q == S_IDLE);
		cmd.cap      = (state_q == S_IDLE) && s_tvalid;
		cmd.clr_wr   = (state_q == S_CLEAR);
		cmd.rd_en    = (state_q == S_READ);
		cmd.upd      = (state_q == S_UPD) && !stat.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (stat.clr_last) begin
						state_q <= pend_q ? S_READ : S_IDLE;
						pend_q  <= 1'b0;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						if (stat.wrap_now) begin
							// epoch counter wraps: wipe the table first
							state_q <= S_CLEAR;
							pend_q  <= 1'b1;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (!stat.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
					pend_q  <= 1'b0;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q |-> state_q == S_CLEAR))
		else $error("pending word outside clearing pass");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cap && stat.wrap_now) |=> (state_q == S_CLEAR && pend_q))
		else $error("epoch wrap did not start clearing pass");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> state_q == S_UPD)
		else $error("table read not followed by update");

endmodule

[sv/cptsm_dp.sv]
// ----------------------------------------------------------------------------
// cptsm_dp
// Datapath: input registers, epoch counter, tag table and result register.
// ----------------------------------------------------------------------------
module cptsm_dp import cptsm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tuser,
	input  logic                   m_tready,
	output logic                   m_tvalid,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	entry_t mem [TAG_COUNT];

	logic [PAGE_W-1:0]     in_page;
	logic [TAG_W-1:0]      in_tag;
	logic [PAGE_BITS-1:0]  page_q;
	logic [TAG_W-1:0]      tag_q;
	logic [TAG_AW-1:0]     addr_q;
	logic                  tag_ok_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic [TAG_AW-1:0]     clr_cnt_q;
	entry_t                rd_q;

	logic                  m_tvalid_q;
	logic [TAG_W-1:0]      tag_out_q;
	logic                  shared_q;
	logic                  fresh_q;

	logic                  hit;
	logic                  upd_we;
	entry_t                upd_wd;
	logic                  sh;
	logic                  fresh;
	logic                  mem_we;
	logic [TAG_AW-1:0]     mem_wa;
	entry_t                mem_wd;

	assign in_page = s_tdata[PAGE_W-1:0];
	assign in_tag  = s_tdata[PAGE_W +: TAG_W];

	assign stat.wrap_now = s_tuser && (epoch_q == EPOCH_MAX);
	assign stat.clr_last = (clr_cnt_q == TAG_AW'(TAG_COUNT - 1));
	assign stat.out_busy = m_tvalid_q && !m_tready;

	// entry counts only if written in the current set
	assign hit = rd_q.seen && (rd_q.epoch == epoch_q);

	always_comb begin
		upd_we = 1'b0;
		upd_wd = rd_q;
		sh     = 1'b0;
		fresh  = 1'b0;
		if (tag_ok_q) begin
			if (!hit) begin
				upd_we       = 1'b1;
				upd_wd.epoch = epoch_q;
				upd_wd.seen  = 1'b1;
				upd_wd.shrd  = 1'b0;
				upd_wd.page  = page_q;
			end else if ((rd_q.page != page_q) && !rd_q.shrd) begin
				upd_we      = 1'b1;
				upd_wd.shrd = 1'b1;
				sh          = 1'b1;
				fresh       = 1'b1;
			end else begin
				sh = rd_q.shrd;
			end
		end
	end

	assign mem_we = cmd.clr_wr || (cmd.upd && upd_we);
	assign mem_wa = cmd.clr_wr ? clr_cnt_q : addr_q;
	assign mem_wd = cmd.clr_wr ? entry_t'('0) : upd_wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			page_q   <= PAGE_BITS'(in_page);
			tag_q    <= in_tag;
			addr_q   <= TAG_AW'(in_tag);
			tag_ok_q <= (in_tag != '0) && (32'(in_tag) < 32'(TAG_COUNT));
		end
		if (cmd.upd) begin
			tag_out_q <= tag_q;
			shared_q  <= sh;
			fresh_q   <= fresh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q    <= '0;
			clr_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.cap && s_tuser) begin
				epoch_q <= (epoch_q == EPOCH_MAX) ? '0 : epoch_q + 1'b1;
			end
			if (cmd.clr_wr) begin
				clr_cnt_q <= stat.clr_last ? '0 : clr_cnt_q + 1'b1;
			end
			if (cmd.upd) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_TDATA_W - TAG_W - 2){1'b0}}, fresh_q, shared_q, tag_out_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> !stat.out_busy)
		else $error("result loaded over an untaken word");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(fresh_q && !shared_q))
		else $error("newly_shared without shared");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_wr && cmd.upd))
		else $error("clear and update write in one cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |=> m_tvalid_q)
		else $error("update did not present a result");

endmodule

[sv/cross_page_tag_share_marker_top.sv]
// ----------------------------------------------------------------------------
// cross_page_tag_share_marker_top
// Marks class tags that appear on more than one page of a set.
// ----------------------------------------------------------------------------
// Each input word (page, tag, start-of-set) gives one output word (tag, shared,
// newly_shared). Each item runs through capture, tag table read, then update and
// result load, as the single-port table needs a read-modify-write.
// The update waits while the previous result has not been taken. After reset
// the block runs a clearing pass over all TAG_COUNT (4096) entries with s_tready low.
// Start-of-set bumps an 8-bit set epoch instead of wiping the table; on every
// 256th start-of-set the epoch wraps and a further clearing pass of the whole
// table runs before that word is handled. Tag 0 leaves the table untouched.
module cross_page_tag_share_marker_top import cptsm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // page[15:0], tag[27:16], zero pad
	input  logic                   s_tuser,   // start_of_set
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // tag_out[11:0], shared, newly_shared, pad
);

	cmd_t  cmd;
	stat_t stat;

	cptsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.stat     (stat),
		.cmd      (cmd)
	);

	cptsm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

	assign s_tready = cmd.in_ready;

endmodule

[dv/cross_page_tag_share_marker_top_tb.sv]
// ----------------------------------------------------------------------------
// cross_page_tag_share_marker_top_tb
// Streams page/tag words through the share marker. A scoreboard keeps its own
// tag table (seen mark, first page, shared flag) and checks every result word.
// ----------------------------------------------------------------------------
module cross_page_tag_share_marker_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cptsm_pkg::*;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic             shared;
		logic             fresh;
	} mark_t;

	class share_board;
		mark_t                due_marks[$];
		bit                   seen_tbl[TAG_COUNT];
		bit                   shared_tbl[TAG_COUNT];
		logic [PAGE_BITS-1:0] first_tbl[TAG_COUNT];
		int                   fails;
		int                   words;
		int                   sets;
		int                   marked;
		int                   checked;

		function void note_word(logic [PAGE_W-1:0] page, logic [TAG_W-1:0] tag, logic sos);
			mark_t m;
			m = '{tag: tag, shared: 1'b0, fresh: 1'b0};
			words++;
			if (sos) begin
				sets++;
				foreach (seen_tbl[i]) begin
					seen_tbl[i]   = 1'b0;
					shared_tbl[i] = 1'b0;
				end
			end
			// tag zero never touches the table
			if (tag != '0 && int'(tag) < TAG_COUNT) begin
				if (!seen_tbl[tag]) begin
					seen_tbl[tag]  = 1'b1;
					first_tbl[tag] = page[PAGE_BITS-1:0];
				end else if (first_tbl[tag] != page[PAGE_BITS-1:0] && !shared_tbl[tag]) begin
					shared_tbl[tag] = 1'b1;
					m.fresh         = 1'b1;
					marked++;
				end
				m.shared = shared_tbl[tag];
			end
			due_marks.push_back(m);
		endfunction

		function void check_word(logic [OUT_TDATA_W-1:0] data);
			mark_t want;
			mark_t got;
			got.tag    = data[TAG_W-1:0];
			got.shared = data[TAG_W];
			got.fresh  = data[TAG_W+1];
			if (due_marks.size() == 0) begin
				$display("%0t: result word %h arrived with nothing pending", $time, data);
				fails++;
				return;
			end
			want = due_marks.pop_front();
			checked++;
			if (got.tag !== want.tag || got.shared !== want.shared || got.fresh !== want.fresh) begin
				$display("%0t: mismatch, expected tag %h shared %b new %b, got tag %h shared %b new %b",
					$time, want.tag, want.shared, want.fresh, got.tag, got.shared, got.fresh);
				fails++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	share_board board = new;
	int         send_idle_pct;
	int         recv_stall_pct;
	int         hold_reqs;

	cross_page_tag_share_marker_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// result side: ready pattern set at the falling edge, long hold-off on request
	initial begin
		int hold_left;
		int hold_done;
		hold_left = 0;
		hold_done = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_reqs != hold_done) begin
				hold_done = hold_reqs;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			board.check_word(m_tdata);
		end
	end

	task automatic send_word(input logic [PAGE_W-1:0] page, input logic [TAG_W-1:0] tag,
			input logic sos);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W-PAGE_W-TAG_W){1'b0}}, tag, page};
		s_tuser  <= sos;
		do @(posedge clk); while (!s_tready);
		board.note_word(page, tag, sos);
	endtask

	// drop valid, then wait for every pending result word
	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.due_marks.size() != 0) @(posedge clk);
	endtask

	// short sets over a narrow tag pool so that tags recur across pages;
	// some sets run on without a start-of-set, some pages jump about
	task automatic run_sets(input int n_items);
		int               left;
		int               len;
		int               pool;
		bit               opens;
		logic [PAGE_W-1:0] page;
		logic [TAG_W-1:0]  tag;
		left = n_items;
		while (left > 0) begin
			len   = ($urandom_range(11) == 0) ? $urandom_range(20, 8) : $urandom_range(4, 1);
			pool  = ($urandom_range(3) == 0) ? 3 : 12;
			opens = ($urandom_range(9) != 0);
			page  = ($urandom_range(5) == 0) ? PAGE_W'($urandom) : PAGE_W'($urandom_range(3));
			for (int i = 0; i < len && left > 0; i++) begin
				case ($urandom_range(15))
					0: tag = '0;
					1: tag = TAG_W'($urandom);
					default: tag = TAG_W'($urandom_range(pool, 1));
				endcase
				if ($urandom_range(9) == 0) begin
					page = PAGE_W'($urandom);
				end else begin
					page = page + PAGE_W'($urandom_range(1));
				end
				send_word(page, tag, opens && i == 0);
				left--;
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_reqs      = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: first sight, same page, new page, flag held, tag zero, extremes
		send_word(16'd0, 12'd5, 1'b0);
		send_word(16'd0, 12'd5, 1'b0);
		send_word(16'd1, 12'd5, 1'b0);
		send_word(16'd2, 12'd5, 1'b0);
		send_word(16'd0, 12'd5, 1'b0);
		send_word(16'd7, 12'd0, 1'b0);
		send_word(16'hFFFF, 12'hFFF, 1'b0);
		send_word(16'd0, 12'hFFF, 1'b0);
		send_word(16'hFFFF, 12'd1, 1'b0);
		send_word(16'hFFFF, 12'd1, 1'b0);
		send_word(16'd10, 12'd3, 1'b0);
		send_word(16'd10, 12'd3, 1'b0);
		send_word(16'd0, 12'd0, 1'b1);
		send_word(16'd9, 12'd5, 1'b0);
		send_word(16'd9, 12'd5, 1'b0);
		send_word(16'd10, 12'd5, 1'b0);
		send_word(16'd10, 12'd5, 1'b1);
		send_word(16'h5555, 12'hAAA, 1'b0);
		send_word(16'hAAAA, 12'h555, 1'b0);
		send_word(16'hAAAA, 12'hAAA, 1'b0);
		send_word(16'h5555, 12'h555, 1'b0);
		send_word(16'd11, 12'd3, 1'b0);
		send_word(16'd12, 12'd3, 1'b0);
		drain;

		// receiver holds off while the sender keeps pushing
		hold_reqs++;
		run_sets(220);
		drain;

		send_idle_pct = 87;
		run_sets(220);
		drain;

		send_idle_pct  = 0;
		recv_stall_pct = 87;
		run_sets(220);
		drain;

		send_idle_pct  = 27;
		recv_stall_pct = 27;
		run_sets(120);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_sets(120);
		drain;

		repeat (20) @(posedge clk);
		$display("tb: %0d words in, %0d results checked, %0d tags newly shared",
			board.words, board.checked, board.marked);
		$display("tb: %0d start-of-set words (%0d epoch wraps), idle and stall phases, long hold-off",
			board.sets, board.sets / 256);
		if (board.fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[files.f]
sv/cptsm_pkg.sv
sv/cptsm_ctrl.sv
sv/cptsm_dp.sv
sv/cross_page_tag_share_marker_top.sv
dv/cross_page_tag_share_marker_top_tb.sv
